/* design/rarsf_pkg.sv */
package rarsf_pkg;

   // number of elements held in the trees
   localparam int SIZE = 1024;
   // memory address width
   localparam int IDX_W = $clog2(SIZE);
   // walk counter width, holds positions up to 2*SIZE-1
   localparam int CNT_W = IDX_W + 1;
   // fixed widths of the transaction fields
   localparam int POS_W = 10;
   localparam int ADD_W = 32;
   localparam int SUM_W = 64;
   // signed add_value times a position of CNT_W bits
   localparam int MUL_W = ADD_W + CNT_W + 1;

   localparam logic [CNT_W-1:0] SIZE_C = CNT_W'(SIZE);
   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(SIZE - 1);

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUM = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [10:0] {
      ST_CLEAR = 11'b000_0000_0001,
      ST_IDLE  = 11'b000_0000_0010,
      ST_APREP = 11'b000_0000_0100,
      ST_ARD   = 11'b000_0000_1000,
      ST_AWR   = 11'b000_0001_0000,
      ST_QPREP = 11'b000_0010_0000,
      ST_QRD   = 11'b000_0100_0000,
      ST_QACC  = 11'b000_1000_0000,
      ST_QMUL  = 11'b001_0000_0000,
      ST_QSUB  = 11'b010_0000_0000,
      ST_DONE  = 11'b100_0000_0000
   } state_type;

endpackage

/* design/range_add_range_sum_fenwick_top.sv */
// range-add / range-sum store over SIZE signed 64-bit elements, kept as two
// binary indexed trees (slope and offset) in two single-port-write memories.
// req channel: one transaction per request. tuser carries the operation
// (add over span or sum over span), tdata carries first_index, last_index and
// add_value. rsp channel: exactly one transaction per request, tdata carries
// range_sum (zero for adds and errors) and status (set for an empty span or a
// span beyond SIZE, in which case nothing changes).
// one request is worked at a time. an add walks the trees from first_index
// and from last_index+1, each read-modify-write step a read state then a
// write state, at most log2(SIZE)+1 steps per walk; a sum walks two
// prefixes, each read step a read state then an accumulate state, at most
// log2(SIZE) steps each, plus a multiply and a subtract per prefix. the next
// request can be taken in the cycle after the response is loaded, even
// while it is still held on rsp.
// if rsp_tready stays low, the finished response waits in its register and
// the following result holds in the engine until the register frees up.
// after reset a clearing pass writes zero to every tree entry, with
// req_tready low; rsp_tvalid is low after reset.
module range_add_range_sum_fenwick_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // first_index[9:0], last_index[19:10], add_value[51:20]
   input  logic [0:0]  req_tuser,  // operation[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata   // range_sum[63:0], status[64]
);

   localparam int CNT_W = rarsf_pkg::CNT_W;
   localparam int IDX_W = rarsf_pkg::IDX_W;
   localparam int POS_W = rarsf_pkg::POS_W;
   localparam int SUM_W = rarsf_pkg::SUM_W;
   localparam int MUL_W = rarsf_pkg::MUL_W;

   logic [SUM_W-1:0] slope_mem  [rarsf_pkg::SIZE];
   logic [SUM_W-1:0] offset_mem [rarsf_pkg::SIZE];

   rarsf_pkg::state_type state_ff, state_in;
   logic                     phase_ff, phase_in;
   logic                     op_ff, op_in;
   logic [POS_W-1:0]         l_ff, l_in;
   logic [POS_W-1:0]         r_ff, r_in;
   logic signed [31:0]       x_ff, x_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         npos_ff, npos_in;
   logic [SUM_W-1:0]         ds_ff, ds_in;
   logic [SUM_W-1:0]         do_ff, do_in;
   logic [SUM_W-1:0]         acc_s_ff, acc_s_in;
   logic [SUM_W-1:0]         acc_o_ff, acc_o_in;
   logic [SUM_W-1:0]         prod_ff, prod_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic                     err_ff, err_in;
   logic [IDX_W-1:0]         clr_ff, clr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]         rsp_sum_ff, rsp_sum_in;
   logic                     rsp_status_ff, rsp_status_in;
   logic [SUM_W-1:0]         rds_ff, rdo_ff;

   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic [IDX_W-1:0]         mem_raddr;
   logic [SUM_W-1:0]         mem_wds, mem_wdo;

   logic [POS_W-1:0]         req_first, req_last;
   logic signed [31:0]       req_value;
   logic                     req_bad;
   logic [CNT_W-1:0]         pos_l, pos_end;
   logic [CNT_W-1:0]         apos;
   logic [CNT_W-1:0]         qpos;
   logic [CNT_W-1:0]         nm1;
   logic [CNT_W-1:0]         anext;
   logic [CNT_W-1:0]         qnext;
   logic signed [MUL_W-1:0]  aprod;
   logic [SUM_W+CNT_W-1:0]   qprod;
   logic [SUM_W-1:0]         x64, p64, pref;

   assign req_first = req_tdata[POS_W-1:0];
   assign req_last  = req_tdata[2*POS_W-1:POS_W];
   assign req_value = $signed(req_tdata[2*POS_W+31:2*POS_W]);
   assign req_bad   = (req_first > req_last) || (32'(req_last) >= rarsf_pkg::SIZE);

   assign pos_l   = CNT_W'(l_ff);
   assign pos_end = CNT_W'(r_ff) + CNT_W'(1);
   assign apos    = phase_ff ? pos_end : pos_l;
   // prefix through l-1 covers l positions, prefix through r covers r+1
   assign qpos    = phase_ff ? pos_l : pos_end;
   assign nm1     = idx_ff - CNT_W'(1);
   assign anext   = idx_ff | (idx_ff + CNT_W'(1));
   assign qnext   = nm1 & idx_ff;

   assign aprod = x_ff * $signed({1'b0, apos});
   assign qprod = acc_s_ff * npos_ff;
   assign x64   = SUM_W'(x_ff);
   assign p64   = SUM_W'(aprod);
   assign pref  = prod_ff - acc_o_ff;

   assign mem_raddr = (state_ff == rarsf_pkg::ST_QRD) ? nm1[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   assign req_tready = (state_ff == rarsf_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_status_ff, rsp_sum_ff};

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      op_in         = op_ff;
      l_in          = l_ff;
      r_in          = r_ff;
      x_in          = x_ff;
      idx_in        = idx_ff;
      npos_in       = npos_ff;
      ds_in         = ds_ff;
      do_in         = do_ff;
      acc_s_in      = acc_s_ff;
      acc_o_in      = acc_o_ff;
      prod_in       = prod_ff;
      sum_in        = sum_ff;
      err_in        = err_ff;
      clr_in        = clr_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[IDX_W-1:0];
      mem_wds       = rds_ff + ds_ff;
      mem_wdo       = rdo_ff + do_ff;

      case (state_ff)
         rarsf_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wds   = '0;
            mem_wdo   = '0;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == rarsf_pkg::LAST_ADDR) begin
               state_in = rarsf_pkg::ST_IDLE;
            end
         end
         rarsf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser[0];
               l_in     = req_first;
               r_in     = req_last;
               x_in     = req_value;
               phase_in = 1'b0;
               sum_in   = '0;
               err_in   = req_bad;
               if (req_bad) begin
                  state_in = rarsf_pkg::ST_DONE;
               end else if (req_tuser[0] == rarsf_pkg::OP_ADD) begin
                  state_in = rarsf_pkg::ST_APREP;
               end else begin
                  state_in = rarsf_pkg::ST_QPREP;
               end
            end
         end
         rarsf_pkg::ST_APREP: begin
            idx_in = apos;
            ds_in  = phase_ff ? -x64 : x64;
            do_in  = phase_ff ? -p64 : p64;
            // span ending at the last element has no end update
            if (phase_ff && (apos >= rarsf_pkg::SIZE_C)) begin
               state_in = rarsf_pkg::ST_DONE;
            end else begin
               state_in = rarsf_pkg::ST_ARD;
            end
         end
         rarsf_pkg::ST_ARD: begin
            state_in = rarsf_pkg::ST_AWR;
         end
         rarsf_pkg::ST_AWR: begin
            mem_we = 1'b1;
            idx_in = anext;
            if (anext >= rarsf_pkg::SIZE_C) begin
               if (phase_ff) begin
                  state_in = rarsf_pkg::ST_DONE;
               end else begin
                  phase_in = 1'b1;
                  state_in = rarsf_pkg::ST_APREP;
               end
            end else begin
               state_in = rarsf_pkg::ST_ARD;
            end
         end
         rarsf_pkg::ST_QPREP: begin
            idx_in   = qpos;
            npos_in  = qpos;
            acc_s_in = '0;
            acc_o_in = '0;
            if (qpos == '0) begin
               state_in = rarsf_pkg::ST_QMUL;
            end else begin
               state_in = rarsf_pkg::ST_QRD;
            end
         end
         rarsf_pkg::ST_QRD: begin
            state_in = rarsf_pkg::ST_QACC;
         end
         rarsf_pkg::ST_QACC: begin
            acc_s_in = acc_s_ff + rds_ff;
            acc_o_in = acc_o_ff + rdo_ff;
            idx_in   = qnext;
            if (qnext == '0) begin
               state_in = rarsf_pkg::ST_QMUL;
            end else begin
               state_in = rarsf_pkg::ST_QRD;
            end
         end
         rarsf_pkg::ST_QMUL: begin
            prod_in  = qprod[SUM_W-1:0];
            state_in = rarsf_pkg::ST_QSUB;
         end
         rarsf_pkg::ST_QSUB: begin
            if (phase_ff) begin
               sum_in   = sum_ff - pref;
               state_in = rarsf_pkg::ST_DONE;
            end else begin
               sum_in   = pref;
               phase_in = 1'b1;
               state_in = rarsf_pkg::ST_QPREP;
            end
         end
         rarsf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_sum_in    = (op_ff == rarsf_pkg::OP_SUM) ? sum_ff : '0;
               rsp_status_in = err_ff ? rarsf_pkg::STATUS_ERR : rarsf_pkg::STATUS_OK;
               state_in      = rarsf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rarsf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rarsf_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff      <= phase_in;
      op_ff         <= op_in;
      l_ff          <= l_in;
      r_ff          <= r_in;
      x_ff          <= x_in;
      idx_ff        <= idx_in;
      npos_ff       <= npos_in;
      ds_ff         <= ds_in;
      do_ff         <= do_in;
      acc_s_ff      <= acc_s_in;
      acc_o_ff      <= acc_o_in;
      prod_ff       <= prod_in;
      sum_ff        <= sum_in;
      err_ff        <= err_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   // tree memories, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slope_mem[mem_waddr]  <= mem_wds;
         offset_mem[mem_waddr] <= mem_wdo;
      end
      rds_ff <= slope_mem[mem_raddr];
      rdo_ff <= offset_mem[mem_raddr];
   end

endmodule

/* design/rarsf_checker.sv */
module rarsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [55:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   // a held response keeps its value until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // one request in flight: ready drops right after a transaction
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in work");

   // reset starts the clearing pass with no response pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block not quiet after reset");

   // an error response carries a zero sum
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> rsp_tdata[63:0] == 64'd0)
      else $error("error response with nonzero sum");

endmodule

bind range_add_range_sum_fenwick_top rarsf_checker u_rarsf_checker (.*);
